// ===== rtl/assert_macros.svh =====
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every cycle outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/csre_pkg.sv =====
`timescale 1ns / 1ps
package csre_pkg;

   localparam int DefEntries = 64;

   localparam logic [1:0] REQ_LOOKUP = 2'd0;
   localparam logic [1:0] REQ_INSERT = 2'd1;
   localparam logic [1:0] REQ_TICK   = 2'd2;

   localparam logic [1:0] POL_LRU  = 2'd0;
   localparam logic [1:0] POL_LFU  = 2'd1;
   localparam logic [1:0] POL_FIFO = 2'd2;

   localparam logic [1:0] REG_ENABLED  = 2'd0;
   localparam logic [1:0] REG_POLICY   = 2'd1;
   localparam logic [1:0] REG_MAXBYTES = 2'd2;
   localparam logic [1:0] REG_INTERVAL = 2'd3;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [63:0] name_key;
      logic [31:0] transaction_id;
      logic [15:0] content_length;
      logic [31:0] freshness_ticks;
      logic [31:0] data_handle;
   } req_word_type;

   typedef struct packed {
      logic        resp_kind;
      logic [31:0] tag_out;
      logic        ok;
      logic [31:0] handle_out;
      logic [6:0]  occupancy;
      logic [31:0] bytes_in_use;
   } rsp_word_type;

   // one slot's stored record (key and payload)
   typedef struct packed {
      logic [63:0] key;
      logic [31:0] handle;
      logic [15:0] bytes;
      logic [31:0] hits;
      logic [31:0] last_use;
      logic [31:0] ins_order;
      logic [32:0] expiry;
   } slot_rec_type;

   localparam int SlotRecW = $bits(slot_rec_type);

endpackage

// ===== rtl/csre_ram.sv =====
`timescale 1ns / 1ps
module csre_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/content_store_replacement_engine_core.sv =====
// content cache with lru / lfu / fifo replacement
//
// req channel: one word per request (lookup, insert or tick); accepted when
// req_valid is high and req_stall low. req_stall stays high while a request is
// in progress or a response word still waits.
// rsp channel: one word per lookup or insert, none per tick; held stable
// while rsp_stall is high, and the next request waits until it is taken.
// scans: an enabled lookup or insert, or a tick with a sweep, scans the slot
// table through the one read port of the slot memory, one slot per cycle. an
// insert is one key scan plus one victim scan per eviction plus a free-slot
// scan over the valid bits. the slot memory read port is the single shared
// scan unit for the key, sweep and victim scans.
// reset: valid bits, counters, time and config registers return to their
// defaults at once; the slot memory needs no clearing as valid bits gate it.
// csr: apb write at byte address 4*i, pready always high, reads return values.
`timescale 1ns / 1ps
module content_store_replacement_engine_core
   import csre_pkg::*;
#(
   parameter int ENTRIES = DefEntries
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
`include "assert_macros.svh"

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1; // key match / sweep scan
   localparam logic [2:0] ST_VICT  = 3'd2; // victim search
   localparam logic [2:0] ST_FREE  = 3'd3; // free slot search + write
   localparam logic [2:0] ST_UPD   = 3'd4; // lookup hit record update
   localparam logic [2:0] ST_RESP  = 3'd5;
   localparam logic [2:0] ST_CHKEV = 3'd6; // decide next eviction

   // configuration
   logic        enabled_ff;
   logic [1:0]  policy_ff;
   logic [31:0] max_bytes_ff;
   logic [15:0] interval_ff;

   // global state
   logic [ENTRIES-1:0] valid_ff;
   logic [31:0] now_ff;
   logic [15:0] sweep_cnt_ff;
   logic [31:0] stamp_ff;
   logic [CW-1:0] total_ff;
   logic [31:0] bytes_ff;

   // sequencer
   logic [2:0]   state_ff;
   req_word_type req_ff;
   logic         sweep_ff;
   logic [AW:0]  idx_ff;      // issue index (one past end signals done)
   logic         rd_vld_ff;   // memory read data belongs to rd_idx_ff
   logic [AW-1:0] rd_idx_ff;
   logic         found_ff;
   logic [AW-1:0] best_idx_ff;
   logic [31:0]  best_score_ff;
   slot_rec_type best_rec_ff;
   logic         rsp_valid_ff;
   rsp_word_type rsp_ff;

   // slot memory
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   slot_rec_type  mem_wdata;
   logic [AW-1:0] mem_raddr;
   slot_rec_type  mem_rdata;
   logic [SlotRecW-1:0] mem_rbits;

   csre_ram #(.Width(SlotRecW), .Depth(ENTRIES)) u_slots (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(mem_raddr),
      .rd_data(mem_rbits)
   );
   assign mem_rdata = slot_rec_type'(mem_rbits);

   // csr port
   logic csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_paddr[3:2])
         REG_ENABLED:  csr_prdata = {31'd0, enabled_ff};
         REG_POLICY:   csr_prdata = {30'd0, policy_ff};
         REG_MAXBYTES: csr_prdata = max_bytes_ff;
         REG_INTERVAL: csr_prdata = {16'd0, interval_ff};
         default:      csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b1;
         policy_ff    <= POL_LRU;
         max_bytes_ff <= 32'd1048576;
         interval_ff  <= 16'd1000;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_ENABLED:  enabled_ff   <= csr_pwdata[0];
            REG_POLICY:   policy_ff    <= csr_pwdata[1:0];
            REG_MAXBYTES: max_bytes_ff <= csr_pwdata;
            REG_INTERVAL: interval_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // handshakes
   logic req_acc;
   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign req_acc   = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // derived values on the record being read back
   logic cur_valid, cur_expired, cur_key_hit;
   logic [31:0] cur_score;
   logic        cur_better;
   logic [32:0] bytes_need;
   logic        over_budget;
   logic [15:0] limit;

   assign cur_valid   = rd_vld_ff && valid_ff[rd_idx_ff];
   assign cur_expired = (mem_rdata.expiry != 33'd0) && ({1'b0, now_ff} >= mem_rdata.expiry);
   assign cur_key_hit = cur_valid && (mem_rdata.key == req_ff.name_key);
   assign bytes_need  = {1'b0, bytes_ff} + {17'd0, req_ff.content_length};
   assign over_budget = bytes_need > {1'b0, max_bytes_ff};
   assign limit       = (interval_ff == 16'd0) ? 16'd1 : interval_ff;

   always_comb begin
      case (policy_ff)
         POL_LFU:  cur_score = mem_rdata.hits;
         POL_FIFO: cur_score = stamp_ff - mem_rdata.ins_order;
         default:  cur_score = stamp_ff - mem_rdata.last_use;
      endcase
      if (policy_ff == POL_LFU) begin
         cur_better = !found_ff || (cur_score < best_score_ff);
      end else begin
         cur_better = !found_ff || (cur_score > best_score_ff);
      end
   end

   // scan end flag and slot memory read address, both from the issue index
   logic scan_end;
   assign scan_end = idx_ff[AW] || (idx_ff == (AW+1)'(ENTRIES));
   assign mem_raddr = idx_ff[AW-1:0];

   // hit update, or insert at first free slot (valid bits scanned one per cycle)
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = best_idx_ff;
      mem_wdata = best_rec_ff;
      if (state_ff == ST_UPD) begin
         mem_we = 1'b1;
         mem_wdata.hits = (best_rec_ff.hits == 32'hFFFF_FFFF) ? best_rec_ff.hits
                          : best_rec_ff.hits + 32'd1;
         mem_wdata.last_use = stamp_ff;
      end else if (state_ff == ST_FREE && !valid_ff[idx_ff[AW-1:0]] && !scan_end) begin
         mem_we    = 1'b1;
         mem_waddr = idx_ff[AW-1:0];
         mem_wdata.key       = req_ff.name_key;
         mem_wdata.handle    = req_ff.data_handle;
         mem_wdata.bytes     = req_ff.content_length;
         mem_wdata.hits      = 32'd0;
         mem_wdata.last_use  = stamp_ff;
         mem_wdata.ins_order = stamp_ff;
         mem_wdata.expiry    = (req_ff.freshness_ticks == 32'd0) ? 33'd0
                               : {1'b0, now_ff} + {1'b0, req_ff.freshness_ticks};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         now_ff       <= 32'd0;
         sweep_cnt_ff <= 16'd0;
         stamp_ff     <= 32'd0;
         total_ff     <= '0;
         bytes_ff     <= 32'd0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         sweep_ff     <= 1'b0;
         idx_ff       <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  req_ff    <= req_word;
                  idx_ff    <= '0;
                  rd_vld_ff <= 1'b0;
                  found_ff  <= 1'b0;
                  sweep_ff  <= 1'b0;
                  rsp_ff.handle_out <= 32'd0;
                  rsp_ff.ok <= 1'b0;
                  case (req_word.req_type)
                     REQ_TICK: begin
                        now_ff <= now_ff + 32'd1;
                        if (sweep_cnt_ff + 16'd1 >= limit) begin
                           sweep_cnt_ff <= 16'd0;
                           sweep_ff     <= 1'b1;
                           state_ff     <= ST_SCAN;
                        end else begin
                           sweep_cnt_ff <= sweep_cnt_ff + 16'd1;
                        end
                     end
                     REQ_LOOKUP, REQ_INSERT: begin
                        if (enabled_ff) begin
                           state_ff <= ST_SCAN;
                        end else begin
                           state_ff <= ST_RESP;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_SCAN: begin
               // issue reads one per cycle, evaluate the read data in the cycle after
               rd_vld_ff <= !scan_end;
               rd_idx_ff <= idx_ff[AW-1:0];
               if (!scan_end) idx_ff <= idx_ff + 1'b1;
               if (sweep_ff) begin
                  if (cur_valid && cur_expired) begin
                     valid_ff[rd_idx_ff] <= 1'b0;
                     total_ff <= total_ff - 1'b1;
                     bytes_ff <= bytes_ff - {16'd0, mem_rdata.bytes};
                  end
                  if (scan_end && !rd_vld_ff) state_ff <= ST_IDLE;
               end else if (cur_key_hit) begin
                  best_idx_ff <= rd_idx_ff;
                  best_rec_ff <= mem_rdata;
                  if (cur_expired) begin
                     valid_ff[rd_idx_ff] <= 1'b0;
                     total_ff <= total_ff - 1'b1;
                     bytes_ff <= bytes_ff - {16'd0, mem_rdata.bytes};
                     state_ff <= (req_ff.req_type == REQ_INSERT) ? ST_CHKEV : ST_RESP;
                  end else if (req_ff.req_type == REQ_INSERT) begin
                     state_ff <= ST_RESP;
                  end else begin
                     state_ff <= ST_UPD;
                  end
               end else if (scan_end && !rd_vld_ff) begin
                  state_ff <= (req_ff.req_type == REQ_INSERT) ? ST_CHKEV : ST_RESP;
               end
            end
            ST_UPD: begin
               stamp_ff          <= stamp_ff + 32'd1;
               rsp_ff.ok         <= 1'b1;
               rsp_ff.handle_out <= best_rec_ff.handle;
               state_ff          <= ST_RESP;
            end
            ST_CHKEV: begin
               idx_ff    <= '0;
               rd_vld_ff <= 1'b0;
               found_ff  <= 1'b0;
               if (total_ff != '0 && (total_ff >= CW'(ENTRIES) || over_budget)) begin
                  state_ff <= ST_VICT;
               end else if (over_budget) begin
                  state_ff <= ST_RESP;
               end else begin
                  state_ff <= ST_FREE;
               end
            end
            ST_VICT: begin
               rd_vld_ff <= !scan_end;
               rd_idx_ff <= idx_ff[AW-1:0];
               if (!scan_end) idx_ff <= idx_ff + 1'b1;
               if (cur_valid && cur_better) begin
                  found_ff      <= 1'b1;
                  best_idx_ff   <= rd_idx_ff;
                  best_score_ff <= cur_score;
                  best_rec_ff   <= mem_rdata;
               end
               if (scan_end && !rd_vld_ff) begin
                  if (found_ff) begin
                     valid_ff[best_idx_ff] <= 1'b0;
                     total_ff <= total_ff - 1'b1;
                     bytes_ff <= bytes_ff - {16'd0, best_rec_ff.bytes};
                  end
                  state_ff <= ST_CHKEV;
               end
            end
            ST_FREE: begin
               // walk valid bits; write happens on the first free slot
               if (scan_end) begin
                  state_ff <= ST_RESP;
               end else if (!valid_ff[idx_ff[AW-1:0]]) begin
                  valid_ff[idx_ff[AW-1:0]] <= 1'b1;
                  total_ff  <= total_ff + 1'b1;
                  bytes_ff  <= bytes_need[31:0];
                  stamp_ff  <= stamp_ff + 32'd1;
                  rsp_ff.ok <= 1'b1;
                  state_ff  <= ST_RESP;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_RESP: begin
               rsp_ff.resp_kind    <= req_ff.req_type[0];
               rsp_ff.tag_out      <= req_ff.transaction_id;
               rsp_ff.occupancy    <= 7'(total_ff);
               rsp_ff.bytes_in_use <= bytes_ff;
               rsp_valid_ff        <= 1'b1;
               state_ff            <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // checks
   `ASSERT_IMPL(a_no_acc_busy, clock, reset, state_ff != ST_IDLE, !req_acc)
   `ASSERT_IMPL(a_total_range, clock, reset, 1'b1, total_ff <= CW'(ENTRIES))
   `ASSERT_NEXT(a_resp_follows, clock, reset, state_ff == ST_RESP, rsp_valid_ff)
   `ASSERT_IMPL(a_total_count, clock, reset, 1'b1, $countones(valid_ff) == 32'(total_ff))

endmodule
